// ----- src/srpb_pkg.sv -----
// ----------------------------------------------------------------------------
// srpb_pkg - shared types and constants of the sparse row pattern builder
// Sizes of the row store and element buffer, status codes, the controller
// state type and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package srpb_pkg;

    localparam int RowCount       = 1024;
    localparam int RowCapacity    = 64;
    localparam int ElementDofsMax = 16;

    localparam int RowW  = $clog2(RowCount);
    localparam int PosW  = $clog2(RowCapacity);
    localparam int LenW  = $clog2(RowCapacity + 1);
    localparam int SlotW = $clog2(ElementDofsMax);
    localparam int FillW = $clog2(ElementDofsMax + 1);
    localparam int DofW  = 11;
    localparam int ColW  = 10;
    localparam int AddrW = RowW + PosW;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ROW_FULL = 2'd1,
        STATUS_RANGE    = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_WAIT,
        ST_PAIR,
        ST_SCAN_REQ,
        ST_SCAN_CHK,
        ST_SHIFT_REQ,
        ST_SHIFT_WR,
        ST_PUT,
        ST_NEXT,
        ST_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic take_item;
        logic read_issue;
        logic read_capture;
        logic pair_start;
        logic scan_issue;
        logic scan_step;
        logic shift_issue;
        logic shift_write;
        logic put;
        logic pair_next;
        logic elem_done;
        logic note_full;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic item_last;
        logic item_mode;
        logic pair_skip;
        logic pairs_done;
        logic scan_end;
        logic scan_found;
        logic scan_past;
        logic row_full;
        logic shift_done;
    } stat_t;

endpackage

// ----- src/srpb_ram.sv -----
// ----------------------------------------------------------------------------
// srpb_ram - generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module srpb_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/srpb_ctrl.sv -----
// ----------------------------------------------------------------------------
// srpb_ctrl - controller of the sparse row pattern builder
// Sequences the clearing pass, reads and the sorted inserts of an element.
// ----------------------------------------------------------------------------
module srpb_ctrl
    import srpb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.item_mode)
                        state_next = ST_READ_WAIT;
                    else if (st.item_last)
                        state_next = ST_PAIR;
                end
            end
            ST_READ_WAIT: state_next = ST_RESULT;
            ST_PAIR:
            begin
                if (st.pairs_done)
                    state_next = ST_RESULT;
                else if (st.pair_skip)
                    state_next = ST_NEXT;
                else
                    state_next = ST_SCAN_REQ;
            end
            ST_SCAN_REQ:
            begin
                if (st.scan_end)
                    state_next = st.row_full ? ST_NEXT : ST_SHIFT_REQ;
                else
                    state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (st.scan_found)
                    state_next = ST_NEXT;
                else if (st.scan_past)
                    state_next = st.row_full ? ST_NEXT : ST_SHIFT_REQ;
                else
                    state_next = ST_SCAN_REQ;
            end
            ST_SHIFT_REQ:
            begin
                if (st.shift_done)
                    state_next = ST_PUT;
                else
                    state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:  state_next = ST_SHIFT_REQ;
            ST_PUT:       state_next = ST_NEXT;
            ST_NEXT:      state_next = ST_PAIR;
            ST_RESULT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_CLEAR:     cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_item = in_valid;
                cmd.read_issue = in_valid & st.item_mode;
                cmd.pair_start = in_valid & ~st.item_mode & st.item_last;
            end
            ST_READ_WAIT: cmd.read_capture = 1'b1;
            ST_PAIR:      cmd.scan_issue = ~st.pairs_done & ~st.pair_skip;
            ST_SCAN_REQ:
            begin
                cmd.note_full = st.scan_end & st.row_full;
            end
            ST_SCAN_CHK:
            begin
                cmd.note_full = ~st.scan_found & st.scan_past & st.row_full;
                cmd.scan_step = ~st.scan_found & ~st.scan_past;
            end
            ST_SHIFT_REQ: cmd.shift_issue = ~st.shift_done;
            ST_SHIFT_WR:  cmd.shift_write = 1'b1;
            ST_PUT:       cmd.put = 1'b1;
            ST_NEXT:      cmd.pair_next = 1'b1;
            ST_RESULT:
            begin
                out_valid     = 1'b1;
                cmd.elem_done = out_ready;
            end
            default:      cmd = '0;
        endcase
    end

endmodule

// ----- src/srpb_dpath.sv -----
// ----------------------------------------------------------------------------
// srpb_dpath - datapath of the sparse row pattern builder
// Element buffer, row length and column stores, scan and shift counters.
// ----------------------------------------------------------------------------
module srpb_dpath
    import srpb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            mode,
    input  logic [DofW-1:0] dof_number,
    input  logic            last_of_element,
    input  logic [9:0]      read_row,
    input  logic [5:0]      read_position,
    input  cmd_t            cmd,
    output stat_t           st,
    output logic            result_kind,
    output logic [1:0]      status,
    output logic [6:0]      row_count,
    output logic [9:0]      column_index,
    output logic            entry_valid
);

    // element buffer
    logic [DofW-1:0]  dofs_reg [ElementDofsMax];
    logic [FillW-1:0] fill_reg;
    status_t          sticky_reg, sticky_next;

    // pair and scan state
    logic [FillW-1:0] r_reg, c_reg;
    logic [RowW-1:0]  row_reg;
    logic [ColW-1:0]  col_reg;
    logic [LenW-1:0]  len_reg;
    logic [LenW-1:0]  pos_reg;
    logic [LenW-1:0]  k_reg;
    logic [RowW-1:0]  clr_reg;
    logic             scan_first_reg;
    logic [LenW-1:0]  len_cur;

    // result register
    logic             kind_reg;
    status_t          stat_out_reg;
    logic [6:0]       cnt_out_reg;
    logic [9:0]       col_out_reg;
    logic             valid_out_reg;
    logic             rd_inrange_reg;
    logic [PosW-1:0]  rd_pos_reg;

    // row length store
    logic             len_we;
    logic [RowW-1:0]  len_addr;
    logic [LenW-1:0]  len_wdata, len_rdata;

    // column store
    logic             col_we;
    logic [AddrW-1:0] col_addr;
    logic [ColW-1:0]  col_wdata, col_rdata;

    logic [DofW-1:0]  dof_fixed;
    logic             dof_range_bad;
    logic [DofW-1:0]  rd_dof, cd_dof;
    logic [DofW-1:0]  rd_m1, cd_m1;

    srpb_ram #(.Width(LenW), .Depth(RowCount)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .addr  (len_addr),
        .wdata (len_wdata),
        .rdata (len_rdata)
    );

    srpb_ram #(.Width(ColW), .Depth(RowCount * RowCapacity)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .addr  (col_addr),
        .wdata (col_wdata),
        .rdata (col_rdata)
    );

    // input dof check
    assign dof_range_bad = ({21'd0, dof_number} > 32'(RowCount));
    assign dof_fixed     = dof_range_bad ? '0 : dof_number;

    // current pair
    assign rd_dof = dofs_reg[r_reg[SlotW-1:0]];
    assign cd_dof = dofs_reg[c_reg[SlotW-1:0]];
    assign rd_m1  = rd_dof - 1'b1;
    assign cd_m1  = cd_dof - 1'b1;

    // row length straight from the store in the first scan cycle
    assign len_cur = scan_first_reg ? len_rdata : len_reg;

    // status towards controller
    always_comb
    begin
        st.clear_last = (clr_reg == RowW'(RowCount - 1));
        st.item_last  = last_of_element;
        st.item_mode  = mode;
        st.pairs_done = (r_reg >= fill_reg);
        st.pair_skip  = (rd_dof == '0) || (cd_dof == '0) || (cd_m1 < rd_m1);
        st.scan_end   = (pos_reg >= len_cur);
        st.scan_found = (col_rdata == col_reg);
        st.scan_past  = (col_rdata > col_reg);
        st.row_full   = (len_cur >= LenW'(RowCapacity));
        st.shift_done = (k_reg <= pos_reg);
    end

    // sticky status update
    always_comb
    begin
        sticky_next = sticky_reg;
        if (cmd.take_item && !mode)
        begin
            if (dof_range_bad)
                sticky_next = STATUS_RANGE;
            else if (fill_reg >= FillW'(ElementDofsMax))
                sticky_next = STATUS_TOO_LONG;
            if (sticky_reg != STATUS_OK)
                sticky_next = sticky_reg;
            else if (dof_range_bad)
                sticky_next = STATUS_RANGE;
        end
        if (cmd.note_full && sticky_reg == STATUS_OK)
            sticky_next = STATUS_ROW_FULL;
        if (cmd.elem_done && kind_reg == KIND_ELEMENT)
            sticky_next = STATUS_OK;
    end

    // memory ports
    always_comb
    begin
        len_we    = 1'b0;
        len_addr  = row_reg;
        len_wdata = len_reg + 1'b1;
        col_we    = 1'b0;
        col_addr  = {row_reg, pos_reg[PosW-1:0]};
        col_wdata = col_reg;
        if (cmd.clear_step)
        begin
            len_we    = 1'b1;
            len_addr  = clr_reg;
            len_wdata = '0;
        end
        else if (cmd.read_issue)
        begin
            len_addr = read_row[RowW-1:0];
            col_addr = {read_row[RowW-1:0], read_position[PosW-1:0]};
        end
        else if (cmd.scan_issue)
        begin
            len_addr = rd_m1[RowW-1:0];
        end
        else if (cmd.shift_issue)
        begin
            col_addr = {row_reg, PosW'(k_reg - 1'b1)};
        end
        else if (cmd.shift_write)
        begin
            col_we    = 1'b1;
            col_addr  = {row_reg, k_reg[PosW-1:0]};
            col_wdata = col_rdata;
        end
        else if (cmd.put)
        begin
            col_we = 1'b1;
            len_we = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            sticky_reg <= STATUS_OK;
            clr_reg    <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
        end
        else
        begin
            sticky_reg <= sticky_next;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.take_item && !mode && fill_reg < FillW'(ElementDofsMax))
                fill_reg <= fill_reg + 1'b1;
            if (cmd.pair_start)
            begin
                r_reg <= '0;
                c_reg <= '0;
            end
            else if (cmd.pair_next)
            begin
                if (c_reg + 1'b1 >= fill_reg)
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            if (cmd.elem_done && kind_reg == KIND_ELEMENT)
            begin
                fill_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item && !mode && fill_reg < FillW'(ElementDofsMax))
            dofs_reg[fill_reg[SlotW-1:0]] <= dof_fixed;
        if (cmd.read_issue)
        begin
            rd_inrange_reg <= ({22'd0, read_row} < 32'(RowCount));
            rd_pos_reg     <= read_position[PosW-1:0];
            kind_reg       <= KIND_READ;
        end
        if (cmd.pair_start)
            kind_reg <= KIND_ELEMENT;
        if (cmd.read_capture)
        begin
            stat_out_reg <= STATUS_OK;
            if (rd_inrange_reg)
            begin
                cnt_out_reg   <= 7'(len_rdata);
                valid_out_reg <= ({1'b0, rd_pos_reg} < len_rdata);
                col_out_reg   <= ({1'b0, rd_pos_reg} < len_rdata) ? 10'(col_rdata) : '0;
            end
            else
            begin
                cnt_out_reg   <= '0;
                valid_out_reg <= 1'b0;
                col_out_reg   <= '0;
            end
        end
        if (cmd.scan_issue)
        begin
            row_reg <= rd_m1[RowW-1:0];
            col_reg <= cd_m1[ColW-1:0];
            pos_reg <= '0;
        end
        if (st.pairs_done && kind_reg == KIND_ELEMENT && !cmd.elem_done)
        begin
            stat_out_reg  <= sticky_reg;
            cnt_out_reg   <= '0;
            col_out_reg   <= '0;
            valid_out_reg <= 1'b0;
        end
        // first cycle of scan: length read lands
        if (cmd.scan_issue)
            len_reg <= '0;
        if (cmd.pair_next || cmd.scan_issue)
            k_reg <= '0;
        if (cmd.scan_step)
            pos_reg <= pos_reg + 1'b1;
        if (cmd.shift_write)
            k_reg <= k_reg - 1'b1;
        if (cmd.put)
            len_reg <= len_reg + 1'b1;
        if (scan_first_reg)
        begin
            len_reg <= len_rdata;
            k_reg   <= len_rdata;
        end
    end

    // marks the cycle in which the row length read returns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_first_reg <= 1'b0;
        else
            scan_first_reg <= cmd.scan_issue;
    end

    assign result_kind  = kind_reg;
    assign status       = stat_out_reg;
    assign row_count    = cnt_out_reg;
    assign column_index = col_out_reg;
    assign entry_valid  = valid_out_reg;

endmodule

// ----- src/sparse_row_pattern_builder_unit.sv -----
// ----------------------------------------------------------------------------
// sparse_row_pattern_builder_unit - upper-triangle sparsity pattern builder
// Buffers element dofs and inserts their pairs into sorted row lists.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  in      | in_valid, in_ready, mode .. read_position   | beat into block
//  out     | out_valid, out_ready, result_kind .. entry_valid | beat out
//
//  A non-last dof beat is stored; a read passes a wait state. A last beat
//  runs each upper-triangle pair of nonzero dofs through a row list scan
//  and, for a new column, a tail shift on the single column RAM port. After
//  reset a clear pass zeroes all 1024 row lengths. One beat is worked at a
//  time; a read or last beat keeps in_ready low until its result is taken.
module sparse_row_pattern_builder_unit
    import srpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [10:0] dof_number,
    input  logic        last_of_element,
    input  logic [9:0]  read_row,
    input  logic [5:0]  read_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [1:0]  status,
    output logic [6:0]  row_count,
    output logic [9:0]  column_index,
    output logic        entry_valid
);

    cmd_t  cmd;
    stat_t st;

    srpb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    srpb_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .dof_number      (dof_number),
        .last_of_element (last_of_element),
        .read_row        (read_row),
        .read_position   (read_position),
        .cmd             (cmd),
        .st              (st),
        .result_kind     (result_kind),
        .status          (status),
        .row_count       (row_count),
        .column_index    (column_index),
        .entry_valid     (entry_valid)
    );

endmodule
